FILE: hw/rtl/lpm_pkg.sv
// Shared types, command codes and helpers for the route table.
`default_nettype none

package lpm_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_W            = 32;
    localparam int LEN_W             = 6;
    localparam int HOP_W             = 32;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [HOP_W-1:0]  hop;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_DONE
    } t_state;

    // Network mask for a prefix length of 0..32.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lpm_cell.sv
// One route slot of the rotating table ring.
`default_nettype none

module lpm_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_shift,
    input  wire lpm_pkg::t_entry i_entry,
    output lpm_pkg::t_entry     o_entry
);

    logic                       r_valid;
    logic [lpm_pkg::ADDR_W-1:0] r_prefix;
    logic [lpm_pkg::LEN_W-1:0]  r_length;
    logic [lpm_pkg::HOP_W-1:0]  r_hop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_prefix <= i_entry.prefix;
            r_length <= i_entry.length;
            r_hop    <= i_entry.hop;
        end
    end

    assign o_entry.valid  = r_valid;
    assign o_entry.prefix = r_prefix;
    assign o_entry.length = r_length;
    assign o_entry.hop    = r_hop;

endmodule

`default_nettype wire

FILE: hw/rtl/longest_prefix_match_table.sv
// Top level: IPv4 longest-prefix-match route table built as a rotating ring of slots.
//
//   channel   signals                                              handshake
//   command   i_command, i_address, i_length, i_next_hop           start / busy
//   result    o_ok, o_hop_out, o_entry_count                       o_result_valid strobe
//
// The slots rotate through a ring of cells; one compare unit sits at cell 0 and sees one
// slot per cycle. Remove and lookup scan one turn of the ring before the result; add does the
// same, and when it fills a free slot a second turn of the ring carries the new route to its
// slot. A new item is taken in the cycle the result is shown. Reset clears the valid bits and
// the count at once; no clearing pass. The receiver cannot stall; each result stands for
// exactly one cycle.
`default_nettype none

module longest_prefix_match_table #(
    parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire  [1:0]                 i_command,
    input  wire  [lpm_pkg::ADDR_W-1:0] i_address,
    input  wire  [lpm_pkg::LEN_W-1:0]  i_length,
    input  wire  [lpm_pkg::HOP_W-1:0]  i_next_hop,
    output logic                       o_result_valid,
    output logic                       o_ok,
    output logic [lpm_pkg::HOP_W-1:0]  o_hop_out,
    output logic [CNT_W-1:0]           o_entry_count
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    lpm_pkg::t_state r_state, n_state;

    logic                       accept;
    logic                       shift;
    logic                       last;
    logic [IDX_W-1:0]           r_idx;

    logic [1:0]                 r_cmd;
    logic [lpm_pkg::ADDR_W-1:0] r_key;
    logic [lpm_pkg::LEN_W-1:0]  r_len;
    logic [lpm_pkg::HOP_W-1:0]  r_hop_in;
    logic                       r_reject, n_reject;

    logic                       r_found, n_found;
    logic                       r_free_seen, n_free_seen;
    logic [IDX_W-1:0]           r_free_idx, n_free_idx;
    logic [lpm_pkg::LEN_W-1:0]  r_best_len, n_best_len;
    logic [lpm_pkg::HOP_W-1:0]  r_best_hop, n_best_hop;

    logic                       r_ok;
    logic [lpm_pkg::HOP_W-1:0]  r_hop;
    logic [CNT_W-1:0]           r_count;

    logic                       route_hit;
    logic                       addr_hit;
    logic                       go_fill;
    logic                       scan_end;
    logic                       fill_end;

    lpm_pkg::t_entry            head;
    lpm_pkg::t_entry            tail;
    lpm_pkg::t_entry            ring [TABLE_ENTRIES];

    // Ring of slots: cell k takes from cell k+1, the last cell takes the edited head.
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        lpm_pkg::t_entry cell_in;
        if (k == TABLE_ENTRIES - 1) begin : g_wrap
            assign cell_in = tail;
        end else begin : g_link
            assign cell_in = ring[k+1];
        end
        lpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_entry (cell_in),
            .o_entry (ring[k])
        );
    end

    assign head = ring[0];

    // State machine: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpm_pkg::S_IDLE: begin
                if (start) n_state = lpm_pkg::S_SCAN;
            end
            lpm_pkg::S_SCAN: begin
                if (last) n_state = go_fill ? lpm_pkg::S_FILL : lpm_pkg::S_DONE;
            end
            lpm_pkg::S_FILL: begin
                if (last) n_state = lpm_pkg::S_DONE;
            end
            lpm_pkg::S_DONE: begin
                n_state = start ? lpm_pkg::S_SCAN : lpm_pkg::S_IDLE;
            end
            default: n_state = lpm_pkg::S_IDLE;
        endcase
    end

    // State machine: outputs.
    always_comb begin
        busy           = 1'b0;
        shift          = 1'b0;
        o_result_valid = 1'b0;
        unique case (r_state)
            lpm_pkg::S_IDLE: ;
            lpm_pkg::S_SCAN, lpm_pkg::S_FILL: begin
                busy  = 1'b1;
                shift = 1'b1;
            end
            lpm_pkg::S_DONE: o_result_valid = 1'b1;
            default: ;
        endcase
    end

    assign accept   = start & ~busy;
    assign last     = (r_idx == LAST_IDX);
    assign scan_end = (r_state == lpm_pkg::S_SCAN) & last;
    assign fill_end = (r_state == lpm_pkg::S_FILL) & last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Rejections known at accept time.
    always_comb begin
        case (i_command)
            lpm_pkg::CMD_ADD:    n_reject = (r_count == FULL_CNT) | (i_length > lpm_pkg::MAX_LEN);
            lpm_pkg::CMD_REMOVE: n_reject = (i_length > lpm_pkg::MAX_LEN);
            lpm_pkg::CMD_LOOKUP: n_reject = 1'b0;
            default:             n_reject = 1'b1;
        endcase
    end

    // Compare unit at the head cell.
    assign route_hit = head.valid & (head.prefix == r_key) & (head.length == r_len);
    assign addr_hit  = head.valid & ((r_key & lpm_pkg::len_mask(head.length)) == head.prefix);

    always_comb begin
        tail        = head;
        n_found     = r_found;
        n_free_seen = r_free_seen;
        n_free_idx  = r_free_idx;
        n_best_len  = r_best_len;
        n_best_hop  = r_best_hop;
        if (r_state == lpm_pkg::S_SCAN && !r_reject) begin
            case (r_cmd)
                lpm_pkg::CMD_ADD: begin
                    if (route_hit && !r_found) begin
                        tail.hop = r_hop_in;
                        n_found  = 1'b1;
                    end
                    if (!head.valid && !r_free_seen) begin
                        n_free_seen = 1'b1;
                        n_free_idx  = r_idx;
                    end
                end
                lpm_pkg::CMD_REMOVE: begin
                    if (route_hit && !r_found) begin
                        tail.valid = 1'b0;
                        n_found    = 1'b1;
                    end
                end
                lpm_pkg::CMD_LOOKUP: begin
                    if (addr_hit && (!r_found || head.length > r_best_len)) begin
                        n_found    = 1'b1;
                        n_best_len = head.length;
                        n_best_hop = head.hop;
                    end
                end
                default: ;
            endcase
        end else if (r_state == lpm_pkg::S_FILL && r_idx == r_free_idx) begin
            tail.valid  = 1'b1;
            tail.prefix = r_key;
            tail.length = r_len;
            tail.hop    = r_hop_in;
        end
    end

    assign go_fill = (r_cmd == lpm_pkg::CMD_ADD) & ~r_reject & ~n_found & n_free_seen;

    // Slot counter: which slot sits in the head cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (shift) begin
            r_idx <= last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (fill_end) begin
            r_count <= r_count + 1'b1;
        end else if (scan_end && r_cmd == lpm_pkg::CMD_REMOVE && !r_reject && n_found
                     && r_count != '0) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Latch the command and mask the prefix for add and remove.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_command;
            r_key       <= (i_command == lpm_pkg::CMD_LOOKUP) ? i_address
                           : (i_address & lpm_pkg::len_mask(i_length));
            r_len       <= i_length;
            r_hop_in    <= i_next_hop;
            r_reject    <= n_reject;
            r_found     <= 1'b0;
            r_free_seen <= 1'b0;
            r_free_idx  <= '0;
            r_best_len  <= '0;
            r_best_hop  <= '0;
        end else begin
            r_found     <= n_found;
            r_free_seen <= n_free_seen;
            r_free_idx  <= n_free_idx;
            r_best_len  <= n_best_len;
            r_best_hop  <= n_best_hop;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (fill_end) begin
            r_ok  <= 1'b1;
            r_hop <= '0;
        end else if (scan_end && !go_fill) begin
            r_ok  <= ~r_reject & n_found;
            r_hop <= (r_cmd == lpm_pkg::CMD_LOOKUP && n_found) ? n_best_hop : '0;
        end
    end

    assign o_ok          = r_ok;
    assign o_hop_out     = r_hop;
    assign o_entry_count = r_count;

endmodule

`default_nettype wire

FILE: dv/longest_prefix_match_table_tb.sv
// Self-checking testbench for the longest-prefix-match route table.
`timescale 1ns / 100ps

module longest_prefix_match_table_tb;

    localparam int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES_DEF;
    localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int ITEM_TARGET   = 1250;
    localparam int QUIET_TAIL    = 150;
    localparam int STALL_LIMIT   = 3000;

    typedef struct {
        logic [1:0]                 command;
        logic [lpm_pkg::ADDR_W-1:0] address;
        logic [lpm_pkg::LEN_W-1:0]  length;
        logic [lpm_pkg::HOP_W-1:0]  next_hop;
        int                         gap;
        bit                         gap_when_free;
        bit                         drain;
    } t_route_cmd;

    typedef struct packed {
        logic                       ok;
        logic [lpm_pkg::HOP_W-1:0]  hop;
        logic [COUNT_W-1:0]         count;
    } t_route_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [1:0]                  i_command = lpm_pkg::CMD_LOOKUP;
    logic [lpm_pkg::ADDR_W-1:0]  i_address = '0;
    logic [lpm_pkg::LEN_W-1:0]   i_length = '0;
    logic [lpm_pkg::HOP_W-1:0]   i_next_hop = '0;
    wire                         busy;
    wire                         o_result_valid;
    wire                         o_ok;
    wire  [lpm_pkg::HOP_W-1:0]   o_hop_out;
    wire  [COUNT_W-1:0]          o_entry_count;

    longest_prefix_match_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_length       (i_length),
        .i_next_hop     (i_next_hop),
        .o_result_valid (o_result_valid),
        .o_ok           (o_ok),
        .o_hop_out      (o_hop_out),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Shadow route table
    bit                          route_valid [TABLE_ENTRIES];
    logic [lpm_pkg::ADDR_W-1:0]  route_pfx   [TABLE_ENTRIES];
    logic [lpm_pkg::LEN_W-1:0]   route_len   [TABLE_ENTRIES];
    logic [lpm_pkg::HOP_W-1:0]   route_hop   [TABLE_ENTRIES];
    int                          route_count = 0;

    t_route_cmd                  pending_items [$];
    t_route_result               route_expect  [$];
    int                          fail_count = 0;

    // Stimulus bookkeeping: routes the generator believes it added
    logic [lpm_pkg::ADDR_W-1:0]  pool_addr [$];
    logic [lpm_pkg::LEN_W-1:0]   pool_len  [$];
    logic [lpm_pkg::ADDR_W-1:0]  route_base [4];
    bit                          gen_quiet = 1'b0;
    bit                          hold_for_drain = 1'b0;

    function automatic logic [lpm_pkg::ADDR_W-1:0] prefix_mask(input logic [5:0] len);
        if (len == 0 || len > 32)
            return '0;
        return 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function automatic int find_route(input logic [31:0] pfx, input logic [5:0] len);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (route_valid[i] && route_pfx[i] == pfx && route_len[i] == len)
                return i;
        end
        return -1;
    endfunction

    function automatic t_route_result apply_route_cmd(input t_route_cmd c);
        t_route_result r;
        logic [31:0]   pfx;
        int            slot;
        int            best;
        r.ok  = 1'b0;
        r.hop = '0;
        best  = -1;
        pfx   = c.address & prefix_mask(c.length);
        slot  = find_route(pfx, c.length);
        case (c.command)
            lpm_pkg::CMD_ADD: begin
                // a full table refuses even an update of an existing route
                if (route_count < TABLE_ENTRIES && c.length <= lpm_pkg::MAX_LEN) begin
                    if (slot < 0) begin
                        for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
                            if (!route_valid[i])
                                slot = i;
                        end
                        route_valid[slot] = 1'b1;
                        route_pfx[slot]   = pfx;
                        route_len[slot]   = c.length;
                        route_count++;
                    end
                    route_hop[slot] = c.next_hop;
                    r.ok = 1'b1;
                end
            end
            lpm_pkg::CMD_REMOVE: begin
                if (c.length <= lpm_pkg::MAX_LEN && slot >= 0) begin
                    route_valid[slot] = 1'b0;
                    route_count--;
                    r.ok = 1'b1;
                end
            end
            lpm_pkg::CMD_LOOKUP: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (route_valid[i] &&
                        (c.address & prefix_mask(route_len[i])) == route_pfx[i] &&
                        (best < 0 || route_len[i] > route_len[best]))
                        best = i;
                end
                if (best >= 0) begin
                    r.ok  = 1'b1;
                    r.hop = route_hop[best];
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(route_count);
        return r;
    endfunction

    function automatic logic [5:0] pick_length(input bit legal_only);
        int r;
        if (legal_only)
            return 6'($urandom_range(8, 32));
        r = $urandom_range(0, 99);
        if (r < 6)
            return 6'd0;
        if (r < 14)
            return 6'd32;
        if (r < 22)
            return 6'($urandom_range(33, 63));
        if (r < 30)
            return 6'($urandom_range(1, 7));
        return 6'($urandom_range(8, 31));
    endfunction

    // Cluster addresses around a few bases so routes nest and overlap
    function automatic logic [31:0] pick_address();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return route_base[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(4, 31));
    endfunction

    task automatic queue_item(input logic [1:0] cmd, input logic [31:0] addr,
                              input logic [5:0] len, input logic [31:0] hop);
        t_route_cmd c;
        c.command       = cmd;
        c.address       = addr;
        c.length        = len;
        c.next_hop      = hop;
        c.gap           = 0;
        c.gap_when_free = $urandom_range(0, 1);
        c.drain         = hold_for_drain;
        hold_for_drain  = 1'b0;
        if (!gen_quiet && pending_items.size() < ITEM_TARGET - QUIET_TAIL &&
            $urandom_range(0, 3) == 0)
            c.gap = $urandom_range(1, 18);
        pending_items.push_back(c);
    endtask

    task automatic add_new_route(input bit legal_only);
        logic [31:0] addr;
        logic [5:0]  len;
        addr = pick_address();
        len  = pick_length(legal_only);
        queue_item(lpm_pkg::CMD_ADD, addr, len, $urandom);
        if (len <= lpm_pkg::MAX_LEN) begin
            pool_addr.push_back(addr & prefix_mask(len));
            pool_len.push_back(len);
        end
    endtask

    // Host bits below the prefix are random; the table must mask them away
    task automatic add_known_route();
        int idx;
        if (pool_addr.size() == 0) begin
            add_new_route(1'b0);
        end else begin
            idx = $urandom_range(0, pool_addr.size() - 1);
            queue_item(lpm_pkg::CMD_ADD,
                       pool_addr[idx] | ($urandom & ~prefix_mask(pool_len[idx])),
                       pool_len[idx], $urandom);
        end
    endtask

    task automatic remove_random();
        queue_item(lpm_pkg::CMD_REMOVE, pick_address(), pick_length(1'b0), $urandom);
    endtask

    task automatic remove_known();
        int idx;
        if (pool_addr.size() == 0) begin
            remove_random();
        end else begin
            idx = $urandom_range(0, pool_addr.size() - 1);
            queue_item(lpm_pkg::CMD_REMOVE,
                       pool_addr[idx] | ($urandom & ~prefix_mask(pool_len[idx])),
                       pool_len[idx], $urandom);
            pool_addr.delete(idx);
            pool_len.delete(idx);
        end
    endtask

    task automatic lookup_route();
        int          idx;
        logic [31:0] addr;
        if (pool_addr.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx  = $urandom_range(0, pool_addr.size() - 1);
            addr = pool_addr[idx] | ($urandom & ~prefix_mask(pool_len[idx]));
        end else begin
            addr = pick_address();
        end
        queue_item(lpm_pkg::CMD_LOOKUP, addr, 6'($urandom_range(0, 63)), $urandom);
    endtask

    task automatic build_stimulus();
        int round;
        round = 0;
        for (int i = 0; i < 4; i++)
            route_base[i] = $urandom;

        // empty table
        queue_item(lpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF);
        queue_item(lpm_pkg::CMD_REMOVE, 32'h0A00_0000, 6'd8, 32'h0);
        // field extremes and nested prefixes
        queue_item(lpm_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        queue_item(lpm_pkg::CMD_ADD, 32'h0000_0000, 6'd0, 32'h1234_5678);
        queue_item(lpm_pkg::CMD_ADD, 32'h0A0B_0C0D, 6'd8, 32'h0000_000A);
        queue_item(lpm_pkg::CMD_ADD, 32'h0A0B_0C0D, 6'd16, 32'h0000_000B);
        queue_item(lpm_pkg::CMD_ADD, 32'h0A0B_0000, 6'd16, 32'h0000_000C);
        queue_item(lpm_pkg::CMD_ADD, 32'h0A0B_0C0D, 6'd33, 32'h0000_00DD);
        queue_item(lpm_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd63, 32'h0000_00EE);
        hold_for_drain = 1'b1;
        queue_item(lpm_pkg::CMD_LOOKUP, 32'h0A0B_FFFF, 6'd63, 32'hFFFF_FFFF);
        queue_item(lpm_pkg::CMD_LOOKUP, 32'h0A01_0000, 6'd0, 32'h0);
        queue_item(lpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'h0);
        queue_item(lpm_pkg::CMD_LOOKUP, 32'h0102_0304, 6'd0, 32'h0);
        queue_item(lpm_pkg::CMD_REMOVE, 32'h0A0B_FFFF, 6'd16, 32'h0);
        queue_item(lpm_pkg::CMD_LOOKUP, 32'h0A0B_0001, 6'd0, 32'h0);
        queue_item(lpm_pkg::CMD_REMOVE, 32'h0A0B_0000, 6'd40, 32'h0);
        queue_item(lpm_pkg::CMD_REMOVE, 32'h0A0B_0000, 6'd16, 32'h0);
        queue_item(lpm_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 6'd0, 32'h0);
        queue_item(lpm_pkg::CMD_LOOKUP, 32'h0102_0304, 6'd0, 32'h0);
        queue_item(lpm_pkg::CMD_ADD, 32'hFFFF_FFFF, 6'd1, 32'h5555_5555);
        queue_item(lpm_pkg::CMD_LOOKUP, 32'hC000_0000, 6'd0, 32'h0);
        queue_item(lpm_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0, 32'h0);

        while (pending_items.size() < ITEM_TARGET) begin
            gen_quiet = ($urandom_range(0, 3) == 0);
            if (round % 6 == 0) begin
                // fill to capacity, probe the full table, then drain a good part of it
                repeat (TABLE_ENTRIES + 2) add_new_route(1'b1);
                add_known_route();
                queue_item(lpm_pkg::CMD_ADD, pick_address(), 6'($urandom_range(33, 63)),
                           $urandom);
                hold_for_drain = 1'b1;
                repeat (4) lookup_route();
                repeat (36) remove_known();
                add_known_route();
            end else begin
                repeat (40) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4:      add_new_route(1'b0);
                        5, 6:               add_known_route();
                        7, 8, 9, 10:        remove_known();
                        11, 12:             remove_random();
                        default:            lookup_route();
                    endcase
                end
            end
            round++;
        end
    endtask

    initial begin
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || start)
            @(negedge i_clk);
        while (route_expect.size() != 0)
            @(negedge i_clk);
        repeat (2 * TABLE_ENTRIES + 10) @(negedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Command driver
    always @(posedge i_clk) begin : drive_proc
        t_route_cmd on_bus;
        int         in_flight;
        int         gap_left;
        bit         gap_loaded;
        bit         take;
        bit         launch;
        if (!i_rst_n) begin
            in_flight  = 0;
            gap_loaded = 1'b0;
            start     <= 1'b0;
        end else begin
            take = start && !busy;
            if (take)
                route_expect.push_back(apply_route_cmd(on_bus));
            in_flight = in_flight + (take ? 1 : 0) - (o_result_valid ? 1 : 0);
            if (in_flight < 0)
                in_flight = 0;

            launch = 1'b0;
            if ((!start || take) && pending_items.size() > 0) begin
                if (!gap_loaded) begin
                    gap_left   = pending_items[0].gap;
                    gap_loaded = 1'b1;
                end
                if (pending_items[0].drain && in_flight != 0) begin
                    // hold until every outstanding result has come back
                end else if (gap_left > 0) begin
                    if (!busy || !pending_items[0].gap_when_free)
                        gap_left--;
                end else begin
                    launch = 1'b1;
                end
            end

            if (launch) begin
                on_bus     = pending_items.pop_front();
                gap_loaded = 1'b0;
                start      <= 1'b1;
                i_command  <= on_bus.command;
                i_address  <= on_bus.address;
                i_length   <= on_bus.length;
                i_next_hop <= on_bus.next_hop;
            end else if (take) begin
                start <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin : check_proc
        t_route_result want;
        if (i_rst_n && o_result_valid) begin
            if (route_expect.size() == 0) begin
                $display("%0t: unexpected result: ok %0b hop %h count %0d",
                         $time, o_ok, o_hop_out, o_entry_count);
                fail_count++;
            end else begin
                want = route_expect.pop_front();
                if (o_ok !== want.ok) begin
                    $display("%0t: ok mismatch: expected %0b actual %0b",
                             $time, want.ok, o_ok);
                    fail_count++;
                end
                if (o_hop_out !== want.hop) begin
                    $display("%0t: hop mismatch: expected %h actual %h",
                             $time, want.hop, o_hop_out);
                    fail_count++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry count mismatch: expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Stall watchdog: count cycles with neither an item taken nor a result shown
    always @(posedge i_clk) begin : stall_proc
        int stall_cycles;
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_cell.sv
hw/rtl/longest_prefix_match_table.sv
dv/longest_prefix_match_table_tb.sv
